>>> sv/bia_pkg.sv
// package for the bytecode integer alu: operation codes, payload structs, widths
// no dependencies
`default_nettype none
package bia_pkg;
   localparam int DataWidth = 32;
   localparam int QuoStepsPerStage = 4;
   localparam int DivStages = DataWidth / QuoStepsPerStage;

   typedef enum logic [3:0] {
      OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
      OP_AND = 4'd4, OP_OR = 4'd5, OP_XOR = 4'd6, OP_SHL = 4'd7,
      OP_SAR = 4'd8, OP_EQ = 4'd9, OP_LT = 4'd10, OP_GT = 4'd11,
      OP_LE = 4'd12, OP_GE = 4'd13, OP_NE = 4'd14, OP_NONE = 4'd15
   } op_type;

   typedef struct packed {
      logic [3:0]        req_type;
      logic signed [31:0] operand_a;
      logic signed [31:0] operand_b;
      logic              byte_compare;
   } req_type_type;

   typedef struct packed {
      logic signed [31:0] result;
      logic              error_code;
   } rsp_type;
endpackage
`default_nettype wire

>>> sv/bia_div.sv
// pipelined restoring divider for unsigned magnitudes, four quotient bits per stage
// depends on bia_pkg
`default_nettype none
module bia_div import bia_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 advance,
   input  wire logic [DataWidth-1:0] dividend,
   input  wire logic [DataWidth-1:0] divisor,
   output logic [DataWidth-1:0]      quotient
);
   logic [DataWidth-1:0] rem_ff [DivStages+1];
   logic [DataWidth-1:0] quo_ff [DivStages+1];
   logic [DataWidth-1:0] dvs_ff [DivStages+1];

   // stage zero captures operands
   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0] <= '0;
         quo_ff[0] <= dividend;
         dvs_ff[0] <= divisor;
      end
   end

   // each stage retires a few quotient bits
   for (genvar s = 0; s < DivStages; s++) begin : g_stage
      logic [DataWidth-1:0] rem_in;
      logic [DataWidth-1:0] quo_in;
      always_comb begin
         logic [DataWidth:0] trial;
         rem_in = rem_ff[s];
         quo_in = quo_ff[s];
         for (int k = 0; k < QuoStepsPerStage; k++) begin
            trial = {rem_in, quo_in[DataWidth-1]} - {1'b0, dvs_ff[s]};
            quo_in = {quo_in[DataWidth-2:0], ~trial[DataWidth]};
            if (!trial[DataWidth]) rem_in = trial[DataWidth-1:0];
            else rem_in = {rem_in[DataWidth-2:0], quo_ff[s][DataWidth-1-k]};
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[s+1] <= rem_in;
            quo_ff[s+1] <= quo_in;
            dvs_ff[s+1] <= dvs_ff[s];
         end
      end
   end

   assign quotient = quo_ff[DivStages];
endmodule
`default_nettype wire

>>> sv/bytecode_integer_alu_top.sv
// 32-bit integer alu for a bytecode interpreter, fully pipelined
// pipeline stages are a decode register, 8 divide stages and an output register;
//   divider stages set the depth
// throughput: one transaction per cycle; a stall freezes the whole pipeline
// reset: synchronous, active high, clears all valid bits
// depends on bia_pkg and bia_div
`default_nettype none
module bytecode_integer_alu_top import bia_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_type_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_type           rsp_data
);
   localparam int Depth = DivStages + 1;

   logic advance;
   logic [Depth:0] vld_ff;
   assign advance   = !(vld_ff[Depth] && rsp_stall);
   assign req_stall = !advance;

   // stage 0: decode, magnitudes, simple ops
   logic [31:0] a, b;
   assign a = req_data.operand_a;
   assign b = req_data.operand_b;

   logic [31:0] mag_a, mag_b, simple_in;
   logic        neg_q_in, zero_in, is_div_in;
   logic [7:0]  ca, cb;
   logic [31:0] ka, kb;
   always_comb begin
      mag_a = a[31] ? 32'(-a) : a;
      mag_b = b[31] ? 32'(-b) : b;
      neg_q_in = a[31] ^ b[31];
      zero_in = (b == '0);
      is_div_in = (op_type'(req_data.req_type) == OP_DIV);
      ca = a[7:0];
      cb = b[7:0];
      ka = req_data.byte_compare ? {{24{ca[7]}}, ca} : a;
      kb = req_data.byte_compare ? {{24{cb[7]}}, cb} : b;
      ka[31] = ~ka[31];
      kb[31] = ~kb[31];
      case (op_type'(req_data.req_type))
         OP_ADD:  simple_in = a + b;
         OP_SUB:  simple_in = a - b;
         OP_MUL:  simple_in = '0;
         OP_AND:  simple_in = a & b;
         OP_OR:   simple_in = a | b;
         OP_XOR:  simple_in = a ^ b;
         OP_SHL:  simple_in = (b >= 32'd32) ? '0 : a << b[4:0];
         OP_SAR:  simple_in = (b >= 32'd32) ? {32{a[31]}} : 32'($signed(a) >>> b[4:0]);
         OP_EQ:   simple_in = {31'd0, ka == kb};
         OP_LT:   simple_in = {31'd0, ka < kb};
         OP_GT:   simple_in = {31'd0, ka > kb};
         OP_LE:   simple_in = {31'd0, ka <= kb};
         OP_GE:   simple_in = {31'd0, ka >= kb};
         OP_NE:   simple_in = {31'd0, ka != kb};
         default: simple_in = '0;
      endcase
   end

   // multiply over two stages: partial products, then sum
   logic [31:0] pp_lo_ff, pp_mid_ff, mul_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         pp_lo_ff  <= 32'(a[15:0] * b[15:0]);
         pp_mid_ff <= 32'((a[31:16] * b[15:0]) + (a[15:0] * b[31:16]));
         mul_ff    <= pp_lo_ff + {pp_mid_ff[15:0], 16'd0};
      end
   end

   // sideband delay line alongside the divider
   logic [31:0] side_ff [Depth];
   logic [Depth-1:0] negq_ff, zero_ff, div_ff, mul_sel_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0]    <= simple_in;
         negq_ff[0]    <= neg_q_in;
         zero_ff[0]    <= zero_in && is_div_in;
         div_ff[0]     <= is_div_in;
         mul_sel_ff[0] <= (op_type'(req_data.req_type) == OP_MUL);
         for (int s = 1; s < Depth; s++) begin
            side_ff[s]    <= (s == 2 && mul_sel_ff[1]) ? mul_ff : side_ff[s-1];
            negq_ff[s]    <= negq_ff[s-1];
            zero_ff[s]    <= zero_ff[s-1];
            div_ff[s]     <= div_ff[s-1];
            mul_sel_ff[s] <= mul_sel_ff[s-1];
         end
      end
   end

   logic [31:0] quo;
   bia_div u_div (
      .clock    (clock),
      .advance  (advance),
      .dividend (mag_a),
      .divisor  (zero_in ? 32'd1 : mag_b),
      .quotient (quo)
   );

   // final select and output register
   rsp_type rsp_in, rsp_ff;
   always_comb begin
      rsp_in.error_code = zero_ff[Depth-1];
      if (zero_ff[Depth-1])    rsp_in.result = '0;
      else if (div_ff[Depth-1]) rsp_in.result = negq_ff[Depth-1] ? 32'(-quo) : quo;
      else                      rsp_in.result = side_ff[Depth-1];
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= {vld_ff[Depth-1:0], req_valid};
   end
   always_ff @(posedge clock) begin
      if (advance) rsp_ff <= rsp_in;
   end

   assign rsp_valid = vld_ff[Depth];
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire
